[sv/rhfd_pkg.sv]
// Shared types and constants of the RTP H.264 FU-A depacketizer.
// No dependencies; every other file refers to it by scoped names.
package rhfd_pkg;

   localparam logic [4:0] FU_A_TYPE     = 5'd28;
   localparam logic [6:0] PT_RESET      = 7'd96;
   localparam int         CMD_DEPTH     = 4;
   localparam int         CMD_PTR_W     = $clog2(CMD_DEPTH);
   localparam int         CMD_CNT_W     = $clog2(CMD_DEPTH + 1);
   // start code (4 bytes) plus the byte that follows it
   localparam logic [2:0] START_RUN_LAST = 3'd4;
   localparam logic [2:0] START_CODE_ONE = 3'd3;

   typedef enum logic [6:0] {
      PH_HDR    = 7'b0000001,
      PH_SKIP   = 7'b0000010,
      PH_FIRST  = 7'b0000100,
      PH_FUHDR  = 7'b0001000,
      PH_SINGLE = 7'b0010000,
      PH_FUDATA = 7'b0100000,
      PH_DROP   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       packet_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        end_of_nal;
      logic [31:0] rtp_timestamp;
      logic        last_of_run;
   } rsp_type;

   // One classified input byte: what the back end has to emit for it.
   typedef struct packed {
      logic        start_code;
      logic [7:0]  data;
      logic        byte_valid;
      logic        end_of_nal;
      logic [31:0] timestamp;
   } cmd_type;

endpackage

[sv/rtp_h264_fu_a_depacketizer.sv]
// RTP H.264 depacketizer (single NAL and FU-A) with Annex-B output.
// A byte's results pass through the command queue and the output register. One
// packet byte per cycle is taken unless the queue is full; a start code burst
// of five results is absorbed by the four-entry queue; then push waits on full.
// Reset (synchronous): queues empty, parser in header phase, payload type 96.
module rtp_h264_fu_a_depacketizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rhfd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rhfd_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data
);

   logic              accept, cmd_push, cmd_pop, cmd_empty;
   rhfd_pkg::cmd_type cmd_in, cmd_head;

   assign accept = req_push && !req_full;

   rhfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_data),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in)
   );

   rhfd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .full      (req_full),
      .empty     (cmd_empty)
   );

   rhfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.byte_valid) |-> (rsp_data.out_byte == 8'd0 &&
       rsp_data.end_of_nal && rsp_data.last_of_run))
      else $error("marker result malformed");

   a_start_code: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.last_of_run) |->
      (rsp_data.byte_valid && !rsp_data.end_of_nal &&
       (rsp_data.out_byte == 8'd0 || rsp_data.out_byte == 8'd1)))
      else $error("start code byte malformed");

   a_eon_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.end_of_nal) |-> rsp_data.last_of_run)
      else $error("end of NAL not on last result of run");

endmodule

[sv/rhfd_front.sv]
// Front end: parses RTP header, extension and FU-A headers, one byte a cycle
// when accepted, turning each into at most one command. Depends on rhfd_pkg.
module rhfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data,
   input  logic             accept,
   input  rhfd_pkg::req_type req,
   output logic             cmd_push,
   output rhfd_pkg::cmd_type cmd
);

   logic [6:0]  pt_ff, pt_in;
   logic [3:0]  hcount_ff, hcount_in;
   logic [17:0] skip_ff, skip_in;
   logic        ext_ff, ext_in;
   logic [31:0] ts_ff, ts_in;
   rhfd_pkg::phase_type phase_ff, phase_in;
   logic        fu_open_ff, fu_open_in;
   logic [2:0]  fubits_ff, fubits_in;
   logic        end_seen_ff, end_seen_in;

   logic        closes, has_res, start_code, bvalid, eon;
   logic [7:0]  data;
   logic [7:0]  b;
   logic [17:0] skip_len;

   assign b        = req.in_byte;
   assign skip_len = {skip_ff[7:0], b, 2'b00};
   assign pt_in    = csr_wr_en ? csr_wr_data : pt_ff;

   always_comb begin
      hcount_in   = hcount_ff;
      skip_in     = skip_ff;
      ext_in      = ext_ff;
      ts_in       = ts_ff;
      phase_in    = phase_ff;
      fu_open_in  = fu_open_ff;
      fubits_in   = fubits_ff;
      end_seen_in = end_seen_ff;
      closes      = 1'b0;
      has_res     = 1'b0;
      start_code  = 1'b0;
      bvalid      = 1'b1;
      eon         = 1'b0;
      data        = b;
      case (phase_ff)
         rhfd_pkg::PH_HDR: begin
            if (hcount_ff == 4'd0) begin
               ext_in = b[4];
            end else if (hcount_ff == 4'd1) begin
               if (b[6:0] != pt_ff) phase_in = rhfd_pkg::PH_DROP;
            end else if (hcount_ff >= 4'd4 && hcount_ff <= 4'd7) begin
               ts_in = {ts_ff[23:0], b};
            end else if (hcount_ff == 4'd14) begin
               skip_in = {10'd0, b};
            end else if (hcount_ff == 4'd15) begin
               skip_in  = skip_len;
               phase_in = (skip_len != 18'd0) ? rhfd_pkg::PH_SKIP : rhfd_pkg::PH_FIRST;
            end
            if (phase_in == rhfd_pkg::PH_HDR) begin
               if (hcount_ff == 4'd11 && !ext_in) phase_in = rhfd_pkg::PH_FIRST;
               else hcount_in = hcount_ff + 4'd1;
            end
         end
         rhfd_pkg::PH_SKIP: begin
            skip_in = skip_ff - 18'd1;
            if (skip_in == 18'd0) phase_in = rhfd_pkg::PH_FIRST;
         end
         rhfd_pkg::PH_FIRST: begin
            if (b[4:0] == rhfd_pkg::FU_A_TYPE) begin
               fubits_in = b[7:5];
               phase_in  = rhfd_pkg::PH_FUHDR;
            end else begin
               start_code = 1'b1;
               has_res    = 1'b1;
               phase_in   = rhfd_pkg::PH_SINGLE;
               closes     = 1'b1;
            end
         end
         rhfd_pkg::PH_FUHDR: begin
            if (b[7]) begin
               // rebuild the NAL header only when no NAL is already open
               if (!fu_open_ff) begin
                  start_code = 1'b1;
                  has_res    = 1'b1;
                  data       = {fubits_ff, b[4:0]};
               end
               fu_open_in  = 1'b1;
               end_seen_in = 1'b0;
               phase_in    = rhfd_pkg::PH_FUDATA;
            end else if (!fu_open_ff) begin
               phase_in = rhfd_pkg::PH_DROP;
            end else begin
               end_seen_in = b[6];
               phase_in    = rhfd_pkg::PH_FUDATA;
               closes      = b[6];
            end
         end
         rhfd_pkg::PH_SINGLE: begin
            has_res = 1'b1;
            closes  = 1'b1;
         end
         rhfd_pkg::PH_FUDATA: begin
            has_res = 1'b1;
            closes  = end_seen_ff;
         end
         default: begin
         end
      endcase
      if (req.packet_end) begin
         if (closes) begin
            eon = 1'b1;
            // empty end fragment: a marker with no byte
            if (!has_res) begin
               has_res = 1'b1;
               data    = 8'd0;
               bvalid  = 1'b0;
            end
            if (phase_in == rhfd_pkg::PH_FUDATA) fu_open_in = 1'b0;
         end
         phase_in    = rhfd_pkg::PH_HDR;
         hcount_in   = 4'd0;
         skip_in     = 18'd0;
         ext_in      = 1'b0;
         end_seen_in = 1'b0;
      end
   end

   assign cmd_push       = accept && has_res;
   assign cmd.start_code = start_code;
   assign cmd.data       = data;
   assign cmd.byte_valid = bvalid;
   assign cmd.end_of_nal = eon;
   assign cmd.timestamp  = ts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff       <= rhfd_pkg::PT_RESET;
         hcount_ff   <= 4'd0;
         skip_ff     <= 18'd0;
         ext_ff      <= 1'b0;
         ts_ff       <= 32'd0;
         phase_ff    <= rhfd_pkg::PH_HDR;
         fu_open_ff  <= 1'b0;
         fubits_ff   <= 3'd0;
         end_seen_ff <= 1'b0;
      end else begin
         pt_ff <= pt_in;
         if (accept) begin
            hcount_ff   <= hcount_in;
            skip_ff     <= skip_in;
            ext_ff      <= ext_in;
            ts_ff       <= ts_in;
            phase_ff    <= phase_in;
            fu_open_ff  <= fu_open_in;
            fubits_ff   <= fubits_in;
            end_seen_ff <= end_seen_in;
         end
      end
   end

endmodule

[sv/rhfd_cmd_fifo.sv]
// Short command queue between front and back end, held in flip-flops.
// Depends on rhfd_pkg.
module rhfd_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rhfd_pkg::cmd_type push_data,
   input  logic             pop,
   output rhfd_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);

   rhfd_pkg::cmd_type slot_ff [rhfd_pkg::CMD_DEPTH];
   logic [rhfd_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rhfd_pkg::CMD_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == rhfd_pkg::CMD_CNT_W'(rhfd_pkg::CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + rhfd_pkg::CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + rhfd_pkg::CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + rhfd_pkg::CMD_CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - rhfd_pkg::CMD_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[sv/rhfd_back.sv]
// Back end: expands each command into one or five results (start code first)
// and holds the oldest result in an output register. Depends on rhfd_pkg.
module rhfd_back (
   input  logic             clock,
   input  logic             reset,
   input  rhfd_pkg::cmd_type cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rhfd_pkg::rsp_type rsp_data
);

   logic [2:0]        step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   rhfd_pkg::rsp_type out_ff, out_in;
   logic              load, is_last;

   assign load    = !cmd_empty && (!out_valid_ff || rsp_pop);
   assign is_last = !cmd.start_code || (step_ff == rhfd_pkg::START_RUN_LAST);
   assign cmd_pop = load && is_last;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      step_in       = step_ff;
      if (rsp_pop) out_valid_in = 1'b0;
      if (load) begin
         out_valid_in           = 1'b1;
         out_in.rtp_timestamp   = cmd.timestamp;
         out_in.last_of_run     = is_last;
         out_in.end_of_nal      = is_last && cmd.end_of_nal;
         out_in.byte_valid      = is_last ? cmd.byte_valid : 1'b1;
         if (is_last) out_in.out_byte = cmd.data;
         else if (step_ff == rhfd_pkg::START_CODE_ONE) out_in.out_byte = 8'd1;
         else out_in.out_byte = 8'd0;
         // advance through the start code, rewind once the command is done
         step_in = is_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
